/* src/ba_pkg.sv */
// Package: shared constants, codes, state and command types for the buddy allocator.
package ba_pkg;

    localparam int MIN_EXP_DEF  = 4;
    localparam int POOL_EXP_DEF = 16;
    localparam int EXP_W        = 5;
    localparam int SIZE_W       = 17;
    localparam int ADDR_W       = 16;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR = 3'd3;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SEARCH, S_POP, S_SPLIT,
        S_LOOKUP, S_MERGE, S_SCAN_RD, S_SCAN_CMP, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_DECODE, OP_SEARCH, OP_POP, OP_SPLIT,
        OP_LOOKUP, OP_MERGE, OP_SCAN_RD, OP_SCAN_CMP, OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic clr_done;
        logic dec_final;
        logic dec_alloc;
        logic search_fail;
        logic search_hit;
        logic split_end;
        logic lookup_final;
        logic merge_top;
        logic scan_end;
        logic scan_found;
        logic out_free;
    } t_dp_stat;

    // bit length of (v - 1): exponent of the power of two that covers v
    function automatic logic [EXP_W-1:0] ceil_log2(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] m;
        logic [EXP_W-1:0]  res;
        m   = v - SIZE_W'(1);
        res = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (m[i]) begin
                res = EXP_W'(i + 1);
            end
        end
        return res;
    endfunction

endpackage

/* src/ba_ram.sv */
// Generic simple dual-port RAM with registered read.
module ba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/ba_datapath.sv */
// Datapath: size table, free stacks, stack heights, counters and result registers.
module ba_datapath #(
    parameter int MIN_EXP  = ba_pkg::MIN_EXP_DEF,
    parameter int POOL_EXP = ba_pkg::POOL_EXP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ba_pkg::t_dp_op              i_op,
    output ba_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                  i_cmd,
    input  logic [ba_pkg::SIZE_W-1:0]   i_request_size,
    input  logic [ba_pkg::ADDR_W-1:0]   i_address,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [2:0]                  o_status,
    output logic [ba_pkg::ADDR_W-1:0]   o_granted_address,
    output logic [ba_pkg::SIZE_W-1:0]   o_granted_size,
    output logic [ba_pkg::SIZE_W-1:0]   o_used_bytes
);
    localparam int UW     = POOL_EXP - MIN_EXP;
    localparam int LEVELS = UW + 1;
    localparam int UNITS  = 1 << UW;
    localparam int SDEPTH = 2 * UNITS;
    localparam int SAW    = UW + 1;
    localparam int HW     = UW + 1;
    localparam int LIW    = $clog2(LEVELS);
    localparam int LVW    = $clog2(LEVELS + 1);
    localparam int EW     = ba_pkg::EXP_W;
    localparam int SW     = ba_pkg::SIZE_W;
    localparam int AW     = ba_pkg::ADDR_W;

    function automatic logic [SAW-1:0] base(input logic [LVW-1:0] k);
        return SAW'(SDEPTH - (SDEPTH >> k));
    endfunction

    function automatic logic [HW-1:0] cap(input logic [LVW-1:0] k);
        return HW'(UNITS >> k);
    endfunction

    logic [1:0]     r_cmd;
    logic [SW-1:0]  r_sz;
    logic [AW-1:0]  r_addr;
    logic [EW-1:0]  r_e;
    logic [UW-1:0]  r_u;
    logic [LVW-1:0] r_k;
    logic [LVW-1:0] r_j;
    logic [HW-1:0]  r_h;
    logic [HW-1:0]  r_r;
    logic [HW-1:0]  r_w;
    logic [SW-1:0]  r_used;
    logic [2:0]     r_status;
    logic [AW-1:0]  r_gaddr;
    logic [SW-1:0]  r_gsize;
    logic [UW-1:0]  r_clr;
    logic [HW-1:0]  r_heights [LEVELS];
    logic           r_ovalid;
    logic [2:0]     r_ostatus;
    logic [AW-1:0]  r_ogaddr;
    logic [SW-1:0]  r_ogsize;
    logic [SW-1:0]  r_oused;

    logic [EW-1:0]  w_clog;
    logic [EW-1:0]  e_al;
    logic           too_big;
    logic           addr_bad;
    logic [UW-1:0]  addr_unit;
    logic           j_in;
    logic [HW-1:0]  hj;
    logic [LVW-1:0] jm;
    logic [HW-1:0]  hjm;
    logic [HW-1:0]  hk;
    logic [UW-1:0]  buddy;
    logic [EW-1:0]  size_e;
    logic           e_bad;
    logic           is_fq;

    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [UW-1:0]  st_wdata;
    logic [SAW-1:0] st_raddr;
    logic [UW-1:0]  st_rdata;
    logic           sz_we;
    logic [UW-1:0]  sz_waddr;
    logic [EW-1:0]  sz_wdata;

    ba_ram #(.WIDTH(EW), .DEPTH(UNITS)) u_size_ram (
        .i_clk  (i_clk),
        .i_we   (sz_we),
        .i_waddr(sz_waddr),
        .i_wdata(sz_wdata),
        .i_raddr(addr_unit),
        .o_rdata(size_e)
    );

    ba_ram #(.WIDTH(UW), .DEPTH(SDEPTH)) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    always_comb begin
        w_clog    = ba_pkg::ceil_log2(r_sz);
        e_al      = (w_clog < EW'(MIN_EXP)) ? EW'(MIN_EXP) : w_clog;
        too_big   = e_al > EW'(POOL_EXP);
        addr_bad  = ((32'(r_addr) >> POOL_EXP) != 32'd0) || (r_addr[MIN_EXP-1:0] != '0);
        addr_unit = UW'(32'(r_addr) >> MIN_EXP);
        is_fq     = (r_cmd == ba_pkg::CMD_FREE) || (r_cmd == ba_pkg::CMD_QUERY);
        j_in      = r_j < LVW'(LEVELS);
        hj        = j_in ? r_heights[r_j[LIW-1:0]] : '0;
        jm        = r_j - LVW'(1);
        hjm       = r_heights[jm[LIW-1:0]];
        hk        = r_heights[r_k[LIW-1:0]];
        buddy     = r_u ^ (UW'(1) << r_k);
        e_bad     = (size_e < EW'(MIN_EXP)) || (size_e > EW'(POOL_EXP));
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_raddr = '0;
        sz_we    = 1'b0;
        sz_waddr = r_u;
        sz_wdata = '0;
        case (i_op)
            ba_pkg::OP_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = base(LVW'(UW));
                sz_we    = 1'b1;
                sz_waddr = r_clr;
            end
            ba_pkg::OP_SEARCH: begin
                st_raddr = base(r_j) + hj - SAW'(1);
            end
            ba_pkg::OP_SPLIT: begin
                if (r_j > r_k) begin
                    st_we    = hjm < cap(jm);
                    st_waddr = base(jm) + hjm;
                    st_wdata = r_u ^ (UW'(1) << jm);
                end else begin
                    sz_we    = 1'b1;
                    sz_wdata = r_e;
                end
            end
            ba_pkg::OP_LOOKUP: begin
                sz_we = !e_bad && (r_cmd == ba_pkg::CMD_FREE);
            end
            ba_pkg::OP_MERGE: begin
                st_we    = (r_k >= LVW'(UW)) && (hk < cap(r_k));
                st_waddr = base(r_k) + hk;
                st_wdata = r_u;
            end
            ba_pkg::OP_SCAN_RD: begin
                st_raddr = base(r_k) + r_r;
                st_we    = (r_r == r_h) && (r_w == r_h) && (hk < cap(r_k));
                st_waddr = base(r_k) + hk;
                st_wdata = r_u;
            end
            ba_pkg::OP_SCAN_CMP: begin
                st_we    = st_rdata != buddy;
                st_waddr = base(r_k) + r_w;
                st_wdata = st_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_heights[i] <= (i == LEVELS - 1) ? HW'(1) : '0;
            end
        end else begin
            if (i_op == ba_pkg::OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_op)
                ba_pkg::OP_CLEAR: begin
                    r_clr <= r_clr + UW'(1);
                end
                ba_pkg::OP_LOAD: begin
                    r_cmd    <= i_cmd;
                    r_sz     <= i_request_size;
                    r_addr   <= i_address;
                    r_status <= ba_pkg::ST_OK;
                    r_gaddr  <= '0;
                    r_gsize  <= '0;
                end
                ba_pkg::OP_DECODE: begin
                    r_e <= e_al;
                    r_k <= LVW'(e_al - EW'(MIN_EXP));
                    r_j <= LVW'(e_al - EW'(MIN_EXP));
                    r_u <= addr_unit;
                    if (r_cmd == ba_pkg::CMD_ALLOC) begin
                        if (r_sz == '0) begin
                            r_status <= ba_pkg::ST_ZERO;
                        end else if (too_big) begin
                            r_status <= ba_pkg::ST_NO_SPACE;
                        end
                    end else if (is_fq && addr_bad) begin
                        r_status <= ba_pkg::ST_BAD_ADDR;
                    end
                end
                ba_pkg::OP_SEARCH: begin
                    if (!j_in) begin
                        r_status <= ba_pkg::ST_NO_SPACE;
                    end else if (hj != '0) begin
                        r_heights[r_j[LIW-1:0]] <= hj - HW'(1);
                    end else begin
                        r_j <= r_j + LVW'(1);
                    end
                end
                ba_pkg::OP_POP: begin
                    r_u <= st_rdata;
                end
                ba_pkg::OP_SPLIT: begin
                    if (r_j > r_k) begin
                        r_j <= jm;
                        if (hjm < cap(jm)) begin
                            r_heights[jm[LIW-1:0]] <= hjm + HW'(1);
                        end
                    end else begin
                        r_used  <= r_used + SW'(32'(1) << r_e);
                        r_gaddr <= AW'(32'(r_u) << MIN_EXP);
                        r_gsize <= SW'(32'(1) << r_e);
                    end
                end
                ba_pkg::OP_LOOKUP: begin
                    if (e_bad) begin
                        r_status <= ba_pkg::ST_NOT_ALLOC;
                    end else if (r_cmd == ba_pkg::CMD_QUERY) begin
                        r_gaddr <= r_addr;
                        r_gsize <= SW'(32'(1) << size_e);
                    end else begin
                        r_used <= r_used - SW'(32'(1) << size_e);
                        r_k    <= LVW'(size_e - EW'(MIN_EXP));
                    end
                end
                ba_pkg::OP_MERGE: begin
                    if (r_k < LVW'(UW)) begin
                        r_r <= '0;
                        r_w <= '0;
                        r_h <= hk;
                    end else if (hk < cap(r_k)) begin
                        r_heights[r_k[LIW-1:0]] <= hk + HW'(1);
                    end
                end
                ba_pkg::OP_SCAN_RD: begin
                    if (r_r == r_h) begin
                        if (r_w != r_h) begin
                            r_heights[r_k[LIW-1:0]] <= r_w;
                            r_u <= r_u & ~(UW'(1) << r_k);
                            r_k <= r_k + LVW'(1);
                        end else if (hk < cap(r_k)) begin
                            r_heights[r_k[LIW-1:0]] <= hk + HW'(1);
                        end
                    end
                end
                ba_pkg::OP_SCAN_CMP: begin
                    if (st_rdata != buddy) begin
                        r_w <= r_w + HW'(1);
                    end
                    r_r <= r_r + HW'(1);
                end
                ba_pkg::OP_EMIT: begin
                    r_ostatus <= r_status;
                    r_ogaddr  <= r_gaddr;
                    r_ogsize  <= r_gsize;
                    r_oused   <= r_used;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.clr_done     = r_clr == '1;
        o_stat.dec_final    = (r_cmd == ba_pkg::CMD_ALLOC) ? ((r_sz == '0) || too_big)
                                                           : (!is_fq || addr_bad);
        o_stat.dec_alloc    = (r_cmd == ba_pkg::CMD_ALLOC) && (r_sz != '0) && !too_big;
        o_stat.search_fail  = !j_in;
        o_stat.search_hit   = j_in && (hj != '0);
        o_stat.split_end    = !(r_j > r_k);
        o_stat.lookup_final = e_bad || (r_cmd != ba_pkg::CMD_FREE);
        o_stat.merge_top    = r_k >= LVW'(UW);
        o_stat.scan_end     = r_r == r_h;
        o_stat.scan_found   = r_w != r_h;
        o_stat.out_free     = !r_ovalid || i_ready;
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_ostatus;
    assign o_granted_address = r_ogaddr;
    assign o_granted_size    = r_ogsize;
    assign o_used_bytes      = r_oused;
endmodule

/* src/ba_ctrl.sv */
// Controller: state machine sequencing clear, decode, search, split and merge.
module ba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ba_pkg::t_dp_stat i_stat,
    output ba_pkg::t_dp_op   o_op
);
    ba_pkg::t_state r_state;
    ba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ba_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = ba_pkg::OP_NONE;
        o_ready = 1'b0;
        unique case (r_state)
            ba_pkg::S_CLEAR: begin
                o_op = ba_pkg::OP_CLEAR;
                if (i_stat.clr_done) n_state = ba_pkg::S_IDLE;
            end
            ba_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_op    = ba_pkg::OP_LOAD;
                    n_state = ba_pkg::S_DECODE;
                end
            end
            ba_pkg::S_DECODE: begin
                o_op = ba_pkg::OP_DECODE;
                if (i_stat.dec_final) n_state = ba_pkg::S_DONE;
                else if (i_stat.dec_alloc) n_state = ba_pkg::S_SEARCH;
                else n_state = ba_pkg::S_LOOKUP;
            end
            ba_pkg::S_SEARCH: begin
                o_op = ba_pkg::OP_SEARCH;
                if (i_stat.search_fail) n_state = ba_pkg::S_DONE;
                else if (i_stat.search_hit) n_state = ba_pkg::S_POP;
            end
            ba_pkg::S_POP: begin
                o_op    = ba_pkg::OP_POP;
                n_state = ba_pkg::S_SPLIT;
            end
            ba_pkg::S_SPLIT: begin
                o_op = ba_pkg::OP_SPLIT;
                if (i_stat.split_end) n_state = ba_pkg::S_DONE;
            end
            ba_pkg::S_LOOKUP: begin
                o_op = ba_pkg::OP_LOOKUP;
                if (i_stat.lookup_final) n_state = ba_pkg::S_DONE;
                else n_state = ba_pkg::S_MERGE;
            end
            ba_pkg::S_MERGE: begin
                o_op = ba_pkg::OP_MERGE;
                if (i_stat.merge_top) n_state = ba_pkg::S_DONE;
                else n_state = ba_pkg::S_SCAN_RD;
            end
            ba_pkg::S_SCAN_RD: begin
                o_op = ba_pkg::OP_SCAN_RD;
                if (i_stat.scan_end) begin
                    n_state = i_stat.scan_found ? ba_pkg::S_MERGE : ba_pkg::S_DONE;
                end else begin
                    n_state = ba_pkg::S_SCAN_CMP;
                end
            end
            ba_pkg::S_SCAN_CMP: begin
                o_op    = ba_pkg::OP_SCAN_CMP;
                n_state = ba_pkg::S_SCAN_RD;
            end
            ba_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_op    = ba_pkg::OP_EMIT;
                    n_state = ba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ba_pkg::S_IDLE;
            end
        endcase
    end
endmodule

/* src/buddy_allocator.sv */
// Top level: binary buddy allocator over one pool, controller plus datapath.
//
//   channel  | handshake          | payload
//   request  | i_valid / o_ready  | i_cmd, i_request_size, i_address
//   result   | o_valid / i_ready  | o_status, o_granted_address, o_granted_size, o_used_bytes
//
// One item at a time. Decode errors and cmd 3 finish after decode; queries and not-allocated
// finish after the size lookup. Allocate searches upward for a free block, pops it and splits
// it down; free merges upward, scanning each level's stack for the buddy, until none is found.
// After reset a clearing pass over all 2^(POOL_EXP-MIN_EXP) entries (4096 by default)
// zeroes the size table; o_ready stays low meanwhile.
// A stalled result holds in the output register; the next item may be taken meanwhile.
module buddy_allocator #(
    parameter int MIN_EXP  = ba_pkg::MIN_EXP_DEF,
    parameter int POOL_EXP = ba_pkg::POOL_EXP_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [ba_pkg::SIZE_W-1:0] i_request_size,
    input  logic [ba_pkg::ADDR_W-1:0] i_address,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [2:0]                o_status,
    output logic [ba_pkg::ADDR_W-1:0] o_granted_address,
    output logic [ba_pkg::SIZE_W-1:0] o_granted_size,
    output logic [ba_pkg::SIZE_W-1:0] o_used_bytes
);
    ba_pkg::t_dp_op   op;
    ba_pkg::t_dp_stat stat;

    ba_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_stat (stat),
        .o_op   (op)
    );

    ba_datapath #(.MIN_EXP(MIN_EXP), .POOL_EXP(POOL_EXP)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .o_stat           (stat),
        .i_cmd            (i_cmd),
        .i_request_size   (i_request_size),
        .i_address        (i_address),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_granted_address(o_granted_address),
        .o_granted_size   (o_granted_size),
        .o_used_bytes     (o_used_bytes)
    );
endmodule
